[design/hvs_pkg.sv]
// Package for the HMM Viterbi state update block.
// Holds widths, function codes, sequencer states, table port type and
// the saturating adder. No dependencies.
package hvs_pkg;

  localparam int MAX_EMIT_STATES = 5;
  localparam int NCOLS           = MAX_EMIT_STATES + 1;
  localparam int TBL_DEPTH       = MAX_EMIT_STATES * NCOLS;
  localparam int TBL_AW          = $clog2(TBL_DEPTH);
  localparam int ST_W            = $clog2(NCOLS);
  localparam int FRAME_BITS      = 20;
  localparam int SCORE_W         = 32;
  localparam int HIST_W          = 25;
  localparam int FUNC_W          = 3;

  localparam logic signed [SCORE_W-1:0] LOG_ZERO_RST = -32'sd939524096;
  localparam logic [2:0]                NUM_EMIT_RST = 3'd3;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN    = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MAX    = {1'b0, {(SCORE_W-1){1'b1}}};

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR = 3'd0,
    FN_ENTER = 3'd1,
    FN_TOKEN = 3'd2,
    FN_FRAME = 3'd3,
    FN_EXIT  = 3'd4,
    FN_LOAD  = 3'd5
  } func_e;

  typedef enum logic [0:0] {
    CFG_NUM_EMIT = 1'b0,
    CFG_LOG_ZERO = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_ACC,
    ST_FIN,
    ST_FIN0,
    ST_XFIN,
    ST_OUT
  } seq_e;

  // table write request
  typedef struct packed {
    logic                      en;
    logic [TBL_AW-1:0]         addr;
    logic signed [SCORE_W-1:0] data;
  } tbl_wr_t;

  function automatic logic signed [SCORE_W-1:0] sat_add(
    input logic signed [SCORE_W-1:0] a,
    input logic signed [SCORE_W-1:0] b
  );
    logic signed [SCORE_W:0] s;
    s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
    if (s[SCORE_W] != s[SCORE_W-1]) begin
      return s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end
    return s[SCORE_W-1:0];
  endfunction

endpackage

[design/hmm_viterbi_state_update.sv]
// Top level of the left-to-right HMM Viterbi state update block.
// Sequencer, state registers and output register; table in hvs_trans_mem.
// Depends on hvs_pkg and hvs_trans_mem.
//
//  port group   dir  carries
//  s_axis_*     in   one request: func, score, data, hist, frame, from, to, sen 0..4
//  m_axis_*     out  one result per request: best, exit token, activated, frame_error
//  cfg_*        in   register write: 0 num_emit_states, 1 log_zero
//
// Clear, enter, token in, load and unknown codes go from idle to output. Exit and
// frame updates scan the n states in use: every add-compare step is a table read
// (ST_RD) then an accumulate (ST_ACC) on the single read port.
// Reset (async, active low) restores all tokens, the configuration and the
// sequencer state; payload registers have no reset, and the table holds garbage
// until loaded. A result waits in the output register; a new request is taken
// while it waits only if it leaves that same cycle.
module hmm_viterbi_state_update (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [2:0] func, [34:3] score, [66:35] data, [91:67] hist, [111:92] frame,
  // [114:112] from_state, [117:115] to_state, [149:118] sen_score_0,
  // [181:150] sen_score_1, [213:182] sen_score_2, [245:214] sen_score_3,
  // [277:246] sen_score_4, [279:278] zero
  input  logic [279:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] best_out, [63:32] exit_score_out, [95:64] exit_data_out,
  // [120:96] exit_hist_out, [121] activated, [122] frame_error, [127:123] zero
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int SW = hvs_pkg::SCORE_W;
  localparam int HW = hvs_pkg::HIST_W;
  localparam int FB = hvs_pkg::FRAME_BITS;
  localparam int NS = hvs_pkg::MAX_EMIT_STATES;
  localparam int XW = hvs_pkg::ST_W;

  // input fields
  logic [2:0]          in_func;
  logic signed [SW-1:0] in_score, in_data;
  logic signed [HW-1:0] in_hist;
  logic [FB-1:0]       in_frame;
  logic [2:0]          in_from, in_to;
  logic signed [SW-1:0] in_sen [NS];

  assign in_func  = s_axis_tdata[2:0];
  assign in_score = s_axis_tdata[34:3];
  assign in_data  = s_axis_tdata[66:35];
  assign in_hist  = s_axis_tdata[91:67];
  assign in_frame = s_axis_tdata[111:92];
  assign in_from  = s_axis_tdata[114:112];
  assign in_to    = s_axis_tdata[117:115];
  assign in_sen[0] = s_axis_tdata[149:118];
  assign in_sen[1] = s_axis_tdata[181:150];
  assign in_sen[2] = s_axis_tdata[213:182];
  assign in_sen[3] = s_axis_tdata[245:214];
  assign in_sen[4] = s_axis_tdata[277:246];

  // configuration
  logic [2:0]           num_emit_q;
  logic signed [SW-1:0] log_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_emit_q <= hvs_pkg::NUM_EMIT_RST;
      log_zero_q <= hvs_pkg::LOG_ZERO_RST;
    end else if (cfg_we_i) begin
      unique case (hvs_pkg::cfg_idx_e'(cfg_idx_i))
        hvs_pkg::CFG_NUM_EMIT: num_emit_q <= cfg_data_i[2:0];
        hvs_pkg::CFG_LOG_ZERO: log_zero_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // states in use, clamped to 1..NS
  logic [XW-1:0] n_eff;
  always_comb begin
    if (num_emit_q == 3'd0) begin
      n_eff = XW'(1);
    end else if (32'(num_emit_q) > NS) begin
      n_eff = XW'(NS);
    end else begin
      n_eff = XW'(num_emit_q);
    end
  end

  // architectural state
  logic signed [SW-1:0] entry_score_q, entry_data_q;
  logic signed [HW-1:0] entry_hist_q;
  logic signed [SW-1:0] score_q [NS];
  logic signed [SW-1:0] sdata_q [NS];
  logic signed [HW-1:0] shist_q [NS];
  logic signed [SW-1:0] exit_score_q, exit_data_q;
  logic signed [HW-1:0] exit_hist_q;
  logic signed [SW-1:0] best_q;
  logic signed [FB:0]   active_frame_q;

  // sequencer working registers
  hvs_pkg::seq_e        state_q, state_d;
  logic                 is_exit_q;
  logic [XW-1:0]        s_q, d_q, src_q;
  logic                 src_v_q;
  logic signed [SW-1:0] sc_q, run_best_q;
  logic signed [SW-1:0] sen_q [NS];
  logic                 act_q, ferr_q;

  // output register
  logic                 out_valid_q;
  logic [127:0]         out_data_q;

  logic accept;
  logic out_free;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // table port
  hvs_pkg::tbl_wr_t            tbl_wr;
  logic [hvs_pkg::TBL_AW-1:0]  rd_addr;
  logic signed [SW-1:0]        t_rd;
  logic [XW-1:0]               col;

  assign col = is_exit_q ? n_eff : d_q;

  hvs_trans_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (t_rd)
  );

  // accumulate step
  logic [XW-1:0]        last_s;
  logic                 t_ok;
  logic signed [SW-1:0] cand;
  logic                 take;

  assign last_s = is_exit_q ? (n_eff - XW'(1)) : d_q;
  assign t_ok   = t_rd > log_zero_q;
  assign cand   = hvs_pkg::sat_add(score_q[s_q], t_rd);
  assign take   = t_ok && (cand >= sc_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hvs_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_func == hvs_pkg::FN_FRAME || in_func == hvs_pkg::FN_EXIT) begin
            state_d = hvs_pkg::ST_RD;
          end else begin
            state_d = hvs_pkg::ST_OUT;
          end
        end
      end
      hvs_pkg::ST_RD: state_d = hvs_pkg::ST_ACC;
      hvs_pkg::ST_ACC: begin
        if (s_q != last_s) begin
          state_d = hvs_pkg::ST_RD;
        end else if (is_exit_q) begin
          state_d = hvs_pkg::ST_XFIN;
        end else if (d_q == '0) begin
          state_d = hvs_pkg::ST_FIN0;
        end else begin
          state_d = hvs_pkg::ST_FIN;
        end
      end
      hvs_pkg::ST_FIN:  state_d = hvs_pkg::ST_RD;
      hvs_pkg::ST_FIN0: state_d = hvs_pkg::ST_OUT;
      hvs_pkg::ST_XFIN: state_d = hvs_pkg::ST_OUT;
      hvs_pkg::ST_OUT:  state_d = hvs_pkg::ST_IDLE;
      default:          state_d = hvs_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (state_q == hvs_pkg::ST_IDLE) && out_free;
    rd_addr       = hvs_pkg::TBL_AW'(s_q) * hvs_pkg::TBL_AW'(hvs_pkg::NCOLS)
                  + hvs_pkg::TBL_AW'(col);
    tbl_wr.en     = accept && (in_func == hvs_pkg::FN_LOAD)
                 && (32'(in_from) < NS) && (32'(in_to) <= NS);
    tbl_wr.addr   = hvs_pkg::TBL_AW'(in_from) * hvs_pkg::TBL_AW'(hvs_pkg::NCOLS)
                  + hvs_pkg::TBL_AW'(in_to);
    tbl_wr.data   = in_score;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hvs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  logic signed [SW-1:0] new_d, new_0;
  logic signed [FB:0]   fr_s;
  assign new_d = hvs_pkg::sat_add(sc_q, sen_q[d_q]);
  assign new_0 = src_v_q ? hvs_pkg::sat_add(sc_q, sen_q[0])
                         : hvs_pkg::sat_add(entry_score_q, sen_q[0]);
  assign fr_s  = signed'({1'b0, in_frame});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_score_q  <= hvs_pkg::LOG_ZERO_RST;
      entry_data_q   <= '0;
      entry_hist_q   <= '1;
      exit_score_q   <= hvs_pkg::LOG_ZERO_RST;
      exit_data_q    <= '0;
      exit_hist_q    <= '1;
      best_q         <= hvs_pkg::LOG_ZERO_RST;
      active_frame_q <= '1;
      act_q          <= 1'b0;
      ferr_q         <= 1'b0;
      is_exit_q      <= 1'b0;
      s_q            <= '0;
      d_q            <= '0;
      src_v_q        <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        score_q[i] <= hvs_pkg::LOG_ZERO_RST;
        sdata_q[i] <= '0;
        shist_q[i] <= '1;
      end
    end else begin
      unique case (state_q)
        hvs_pkg::ST_IDLE: begin
          if (accept) begin
            act_q  <= 1'b0;
            ferr_q <= 1'b0;
            s_q    <= '0;
            src_v_q <= 1'b0;
            unique case (in_func)
              hvs_pkg::FN_CLEAR: begin
                entry_score_q <= log_zero_q;
                entry_hist_q  <= '1;
                for (int i = 0; i < NS; i++) begin
                  if (i < 32'(n_eff)) begin
                    score_q[i] <= log_zero_q;
                    shist_q[i] <= '1;
                  end
                end
                exit_score_q   <= log_zero_q;
                exit_hist_q    <= '1;
                best_q         <= log_zero_q;
                active_frame_q <= '1;
              end
              hvs_pkg::FN_ENTER: begin
                entry_score_q  <= in_score;
                entry_data_q   <= in_data;
                entry_hist_q   <= in_hist;
                active_frame_q <= fr_s;
              end
              hvs_pkg::FN_TOKEN: begin
                if (entry_score_q < in_score) begin
                  entry_score_q <= in_score;
                  entry_data_q  <= in_data;
                  entry_hist_q  <= in_hist;
                  if (active_frame_q < fr_s) begin
                    active_frame_q <= fr_s;
                    act_q          <= 1'b1;
                  end else if (active_frame_q > fr_s) begin
                    ferr_q <= 1'b1;
                  end
                end
              end
              hvs_pkg::FN_FRAME: begin
                is_exit_q <= 1'b0;
                // top column first; with one state go straight to state 0
                d_q  <= n_eff - XW'(1);
                sc_q <= (n_eff == XW'(1)) ? entry_score_q : log_zero_q;
              end
              hvs_pkg::FN_EXIT: begin
                is_exit_q <= 1'b1;
                sc_q      <= log_zero_q;
              end
              default: ;
            endcase
          end
        end
        hvs_pkg::ST_ACC: begin
          if (take) begin
            sc_q    <= cand;
            src_q   <= s_q;
            src_v_q <= 1'b1;
          end
          if (s_q != last_s) begin
            s_q <= s_q + XW'(1);
          end
        end
        hvs_pkg::ST_FIN: begin
          // lower states still hold last frame's values when read later
          score_q[d_q] <= new_d;
          if (src_v_q) begin
            sdata_q[d_q] <= sdata_q[src_q];
            shist_q[d_q] <= shist_q[src_q];
          end
          d_q     <= d_q - XW'(1);
          s_q     <= '0;
          src_v_q <= 1'b0;
          sc_q    <= (d_q == XW'(1)) ? entry_score_q : log_zero_q;
        end
        hvs_pkg::ST_FIN0: begin
          score_q[0] <= new_0;
          if (!src_v_q) begin
            sdata_q[0] <= entry_data_q;
            shist_q[0] <= entry_hist_q;
          end
          entry_score_q <= log_zero_q;
          best_q <= (new_0 > run_best_q) ? new_0 : run_best_q;
        end
        hvs_pkg::ST_XFIN: begin
          exit_score_q <= sc_q;
          if (src_v_q) begin
            exit_data_q <= sdata_q[src_q];
            exit_hist_q <= shist_q[src_q];
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers without reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < NS; i++) begin
        sen_q[i] <= in_sen[i];
      end
    end
    if (accept && in_func == hvs_pkg::FN_FRAME) begin
      run_best_q <= hvs_pkg::SCORE_MIN;
    end else if (state_q == hvs_pkg::ST_FIN && new_d > run_best_q) begin
      run_best_q <= new_d;
    end
    if (state_q == hvs_pkg::ST_OUT) begin
      out_data_q <= {5'd0, ferr_q, act_q, exit_hist_q, exit_data_q,
                     exit_score_q, best_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == hvs_pkg::ST_OUT) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == hvs_pkg::ST_IDLE)
    else $error("request taken while busy");

  a_rd_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hvs_pkg::ST_RD |=> state_q == hvs_pkg::ST_ACC)
    else $error("table read not followed by accumulate");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hvs_pkg::ST_ACC |-> s_q <= last_s && 32'(d_q) < NS)
    else $error("scan index out of range");

  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hvs_pkg::ST_OUT |-> !out_valid_q)
    else $error("result would overwrite pending result");

endmodule

[design/hvs_trans_mem.sv]
// Transition probability table: one write port, one registered read port.
// Depends on hvs_pkg.
module hvs_trans_mem (
  input  logic                              clk_i,
  input  hvs_pkg::tbl_wr_t                  wr_i,
  input  logic [hvs_pkg::TBL_AW-1:0]        rd_addr_i,
  output logic signed [hvs_pkg::SCORE_W-1:0] rd_data_o
);

  logic signed [hvs_pkg::SCORE_W-1:0] mem [hvs_pkg::TBL_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

[bench/tb_top.sv]
// Self-checking bench for hmm_viterbi_state_update: stream requests in, one result out per
// request, results checked against an in-bench Viterbi token predictor.
// Depends on hvs_pkg and the design sources.
`timescale 1ns / 1ps

module tb_top;

  // codes the design leaves unnamed: they must act as no-ops
  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [2:0]         func;
    logic signed [31:0] score;
    logic signed [31:0] data;
    logic [24:0]        hist;
    logic [19:0]        frame;
    logic [2:0]         from_st;
    logic [2:0]         to_st;
    logic signed [31:0] sen [5];
  } hmm_req_t;

  typedef struct {
    logic signed [31:0] best;
    logic signed [31:0] xscore;
    logic signed [31:0] xdata;
    logic [24:0]        xhist;
    logic               act;
    logic               ferr;
  } hmm_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [279:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [0:0]   cfg_idx_i = hvs_pkg::CFG_NUM_EMIT;
  logic [31:0]  cfg_data_i = '0;

  hmm_viterbi_state_update dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------- predictor state ----------------
  logic [2:0]         p_num;
  logic signed [31:0] p_lz;
  logic signed [31:0] p_entry_sc, p_entry_dt;
  logic [24:0]        p_entry_hs;
  logic signed [31:0] p_st_sc [5];
  logic signed [31:0] p_st_dt [5];
  logic [24:0]        p_st_hs [5];
  logic signed [31:0] p_x_sc, p_x_dt;
  logic [24:0]        p_x_hs;
  logic signed [31:0] p_best;
  int                 p_afr;
  logic signed [31:0] p_tbl [5][6];

  hmm_res_t expected_q[$];
  int       n_fail = 0;
  bit       quiet = 0;
  int       hold_cycles = 0;

  function automatic logic signed [31:0] sadd(logic signed [31:0] a, logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s < longint'(S_MIN)) return S_MIN;
    if (s > longint'(S_MAX)) return S_MAX;
    return s[31:0];
  endfunction

  function automatic int used_states();
    if (p_num == 0) return 1;
    if (p_num > 5) return 5;
    return p_num;
  endfunction

  task automatic predict_hmm(input hmm_req_t r, output hmm_res_t e);
    int n, src;
    logic signed [31:0] sc, c, t, bst;
    e.act  = 0;
    e.ferr = 0;
    n = used_states();
    case (r.func)
      hvs_pkg::FN_CLEAR: begin
        p_entry_sc = p_lz;
        p_entry_hs = '1;
        for (int i = 0; i < n; i++) begin
          p_st_sc[i] = p_lz;
          p_st_hs[i] = '1;          // data words stay stale
        end
        p_x_sc = p_lz;
        p_x_hs = '1;
        p_best = p_lz;
        p_afr  = -1;
      end
      hvs_pkg::FN_ENTER: begin
        p_entry_sc = r.score;
        p_entry_dt = r.data;
        p_entry_hs = r.hist;
        p_afr      = int'(r.frame);
      end
      hvs_pkg::FN_TOKEN: begin
        if (p_entry_sc < r.score) begin
          p_entry_sc = r.score;
          p_entry_dt = r.data;
          p_entry_hs = r.hist;
          if (p_afr < int'(r.frame)) begin
            p_afr = int'(r.frame);
            e.act = 1;
          end else if (p_afr > int'(r.frame)) begin
            e.ferr = 1;               // late active frame: keep it, flag
          end
        end
      end
      hvs_pkg::FN_FRAME: begin
        bst = S_MIN;
        for (int d = n - 1; d > 0; d--) begin
          sc  = p_lz;
          src = -1;
          for (int s = 0; s <= d; s++) begin
            t = p_tbl[s][d];
            if (t > p_lz) begin
              c = sadd(p_st_sc[s], t);
              if (c >= sc) begin
                sc  = c;
                src = s;
              end
            end
          end
          if (src >= 0) begin
            p_st_dt[d] = p_st_dt[src];
            p_st_hs[d] = p_st_hs[src];
          end
          p_st_sc[d] = sadd(sc, r.sen[d]);
          if (bst < p_st_sc[d]) bst = p_st_sc[d];
        end
        t = p_tbl[0][0];
        c = sadd(p_st_sc[0], t);
        if (t > p_lz && c >= p_entry_sc) begin
          p_st_sc[0] = sadd(c, r.sen[0]);
        end else begin
          p_st_sc[0] = sadd(p_entry_sc, r.sen[0]);
          p_st_dt[0] = p_entry_dt;
          p_st_hs[0] = p_entry_hs;
        end
        if (bst < p_st_sc[0]) bst = p_st_sc[0];
        p_entry_sc = p_lz;
        p_best     = bst;
      end
      hvs_pkg::FN_EXIT: begin
        sc  = p_lz;
        src = -1;
        for (int s = 0; s < n; s++) begin
          t = p_tbl[s][n];
          if (t > p_lz) begin
            c = sadd(p_st_sc[s], t);
            if (c >= sc) begin
              sc  = c;
              src = s;
            end
          end
        end
        p_x_sc = sc;
        if (src >= 0) begin
          p_x_dt = p_st_dt[src];
          p_x_hs = p_st_hs[src];
        end
      end
      hvs_pkg::FN_LOAD: begin
        if (r.from_st < 5 && r.to_st <= 5) p_tbl[r.from_st][r.to_st] = r.score;
      end
      default: ;
    endcase
    e.best   = p_best;
    e.xscore = p_x_sc;
    e.xdata  = p_x_dt;
    e.xhist  = p_x_hs;
  endtask

  task automatic predictor_reset();
    p_num = hvs_pkg::NUM_EMIT_RST;
    p_lz  = hvs_pkg::LOG_ZERO_RST;
    p_entry_sc = p_lz; p_entry_dt = 0; p_entry_hs = '1;
    for (int i = 0; i < 5; i++) begin
      p_st_sc[i] = p_lz; p_st_dt[i] = 0; p_st_hs[i] = '1;
    end
    p_x_sc = p_lz; p_x_dt = 0; p_x_hs = '1;
    p_best = p_lz;
    p_afr  = -1;
  endtask

  // ---------------- request driver ----------------
  task automatic send_req(input hmm_req_t r);
    hmm_res_t e;
    int gap;
    s_axis_tdata <= {2'b00, r.sen[4], r.sen[3], r.sen[2], r.sen[1], r.sen[0], r.to_st,
                     r.from_st, r.frame, r.hist, r.data, r.score, r.func};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_hmm(r, e);
    expected_q.push_back(e);
    gap = (!quiet && $urandom_range(3) == 0) ? $urandom_range(7, 1) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic stop_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // only while idle: every result in, plus slack
  task automatic write_reg(input hvs_pkg::cfg_idx_e idx, input logic [31:0] val);
    stop_sender();
    wait (expected_q.size() == 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == hvs_pkg::CFG_NUM_EMIT) p_num = val[2:0];
    else p_lz = val;
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk_i) begin
    hmm_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        n_fail++;
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== e.best) begin
          $error("best_out exp %0d got %0d", e.best, $signed(m_axis_tdata[31:0]));
          n_fail++;
        end
        if (m_axis_tdata[63:32] !== e.xscore) begin
          $error("exit_score_out exp %0d got %0d", e.xscore, $signed(m_axis_tdata[63:32]));
          n_fail++;
        end
        if (m_axis_tdata[95:64] !== e.xdata) begin
          $error("exit_data_out exp %0d got %0d", e.xdata, $signed(m_axis_tdata[95:64]));
          n_fail++;
        end
        if (m_axis_tdata[120:96] !== e.xhist) begin
          $error("exit_hist_out exp %h got %h", e.xhist, m_axis_tdata[120:96]);
          n_fail++;
        end
        if (m_axis_tdata[121] !== e.act) begin
          $error("activated exp %b got %b", e.act, m_axis_tdata[121]);
          n_fail++;
        end
        if (m_axis_tdata[122] !== e.ferr) begin
          $error("frame_error exp %b got %b", e.ferr, m_axis_tdata[122]);
          n_fail++;
        end
      end
    end
  end

  // result side backpressure: random bursts, or a long hold on request
  always @(posedge clk_i) begin
    int stall;
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall > 0) begin
      m_axis_tready <= 1'b0;
      stall--;
    end else if ($urandom_range(4) == 0) begin
      m_axis_tready <= 1'b0;
      stall = $urandom_range(6);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------- stimulus helpers ----------------
  function automatic logic signed [31:0] rnd_score();
    case ($urandom_range(7))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return p_lz;
      3:       return $urandom;
      4:       return -$signed(32'($urandom_range(200000)));
      default: return -$signed(32'($urandom_range(3000)));
    endcase
  endfunction

  function automatic hmm_req_t rnd_req(logic [2:0] f);
    hmm_req_t r;
    r.func    = f;
    r.score   = rnd_score();
    r.data    = $urandom;
    r.hist    = ($urandom_range(3) == 0) ? '1 : 25'($urandom);
    r.frame   = ($urandom_range(7) == 0) ? '1 : 20'($urandom_range(50));
    r.from_st = 3'($urandom);
    r.to_st   = 3'($urandom);
    for (int i = 0; i < 5; i++) r.sen[i] = rnd_score();
    return r;
  endfunction

  task automatic load_entry(input int fr, input int to, input logic signed [31:0] v);
    hmm_req_t r;
    r = rnd_req(hvs_pkg::FN_LOAD);
    r.from_st = 3'(fr);
    r.to_st   = 3'(to);
    r.score   = v;
    send_req(r);
  endtask

  // ---------------- tests ----------------
  task automatic test_table_load();
    for (int s = 0; s < 5; s++)
      for (int d = 0; d < 6; d++)
        load_entry(s, d, ($urandom_range(3) == 0) ? p_lz : -$signed(32'($urandom_range(5000))));
  endtask

  task automatic test_directed();
    hmm_req_t r;
    r = rnd_req(hvs_pkg::FN_ENTER); r.score = -100; r.frame = 4; send_req(r);
    r = rnd_req(hvs_pkg::FN_TOKEN); r.score = -50;  r.frame = 5; send_req(r);   // activates
    r = rnd_req(hvs_pkg::FN_TOKEN); r.score = -10;  r.frame = 2; send_req(r);   // late frame
    r = rnd_req(hvs_pkg::FN_TOKEN); r.score = -900; r.frame = 9; send_req(r);   // loses
    r = rnd_req(hvs_pkg::FN_TOKEN); r.score = S_MAX; r.frame = '1; send_req(r);
    r = rnd_req(hvs_pkg::FN_FRAME); for (int i = 0; i < 5; i++) r.sen[i] = S_MAX; send_req(r);
    r = rnd_req(hvs_pkg::FN_FRAME); for (int i = 0; i < 5; i++) r.sen[i] = S_MIN; send_req(r);
    send_req(rnd_req(hvs_pkg::FN_EXIT));
    send_req(rnd_req(hvs_pkg::FN_CLEAR));
    send_req(rnd_req(hvs_pkg::FN_FRAME));        // stale data words after clear
    send_req(rnd_req(hvs_pkg::FN_EXIT));
    send_req(rnd_req(FN_SPARE6));
    send_req(rnd_req(FN_SPARE7));
    r = rnd_req(hvs_pkg::FN_ENTER); r.score = S_MIN; r.hist = '1; r.frame = 0; send_req(r);
    r = rnd_req(hvs_pkg::FN_TOKEN); r.score = S_MIN; send_req(r);               // ties never win
    load_entry(5, 0, 0);
    load_entry(7, 3, 0);
    load_entry(2, 6, 0);
    load_entry(4, 7, 0);
    r = rnd_req(hvs_pkg::FN_FRAME); send_req(r);
    send_req(rnd_req(hvs_pkg::FN_EXIT));
  endtask

  // one utterance-like run: enter, tokens, frames, exit; plus some noise
  task automatic test_random_runs(input int count);
    hmm_req_t r;
    int sent, fr;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(4) == 0) begin
        r = rnd_req(3'($urandom));
        if (r.func == hvs_pkg::FN_LOAD && $urandom_range(1)) r.score = p_lz;
        send_req(r);
        sent++;
      end else begin
        fr = $urandom_range(1000);
        if ($urandom_range(3) == 0) begin send_req(rnd_req(hvs_pkg::FN_CLEAR)); sent++; end
        r = rnd_req(hvs_pkg::FN_ENTER); r.frame = 20'(fr); send_req(r); sent++;
        repeat ($urandom_range(4)) begin
          r = rnd_req(hvs_pkg::FN_TOKEN);
          r.frame = 20'(fr + $urandom_range(2) - 1);
          send_req(r);
          sent++;
          fr = fr + 1;
          send_req(rnd_req(hvs_pkg::FN_FRAME));
          send_req(rnd_req(hvs_pkg::FN_EXIT));
          sent += 2;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    test_random_runs(20);
  endtask

  initial begin
    predictor_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_load();
    test_directed();
    write_reg(hvs_pkg::CFG_NUM_EMIT, 32'd5);
    write_reg(hvs_pkg::CFG_LOG_ZERO, S_MIN);
    test_directed();
    test_backpressure();
    write_reg(hvs_pkg::CFG_NUM_EMIT, 32'd0);
    write_reg(hvs_pkg::CFG_LOG_ZERO, 32'd0);
    test_random_runs(100);
    write_reg(hvs_pkg::CFG_NUM_EMIT, 32'd7);
    write_reg(hvs_pkg::CFG_LOG_ZERO, -32'sd3000);
    test_random_runs(120);
    write_reg(hvs_pkg::CFG_NUM_EMIT, 32'd1);
    write_reg(hvs_pkg::CFG_LOG_ZERO, hvs_pkg::LOG_ZERO_RST);
    test_random_runs(120);
    write_reg(hvs_pkg::CFG_NUM_EMIT, 32'd2);
    write_reg(hvs_pkg::CFG_LOG_ZERO, -32'sd1500);
    test_random_runs(120);
    write_reg(hvs_pkg::CFG_NUM_EMIT, 32'd4);
    test_random_runs(120);
    write_reg(hvs_pkg::CFG_NUM_EMIT, 32'd6);
    write_reg(hvs_pkg::CFG_LOG_ZERO, -32'sd4000);
    quiet = 1;
    test_random_runs(150);
    stop_sender();

    wait (expected_q.size() == 0);
    repeat (60) @(posedge clk_i);
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("FAIL");
    $finish;
  end

endmodule
